>>> design/lrcs_pkg.sv
`default_nettype none
package lrcs_pkg;

	localparam int unsigned MAX_TEXTURE_WIDTH = 16384;
	localparam int unsigned DIV_STAGES = 8;
	localparam int unsigned DIV_STEP = 4;
	localparam int unsigned TB_RESET = 4;

	typedef struct packed {
		logic [13:0] x;
		logic [31:0] y;
		logic [14:0] width;
		logic [31:0] height;
		logic [31:0] offset;
	} region_t;

endpackage
`default_nettype wire

>>> design/lrcs_if.sv
`default_nettype none
interface lrcs_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_byte;
	logic [31:0] byte_length;
	logic [14:0] texture_width;

	modport source (output valid, start_byte, byte_length, texture_width, input ready);
	modport sink (input valid, start_byte, byte_length, texture_width, output ready);
endinterface

interface lrcs_rgn_if;
	logic        valid;
	logic        ready;
	logic [13:0] region_x;
	logic [31:0] region_y;
	logic [14:0] region_width;
	logic [31:0] region_height;
	logic [31:0] source_offset;
	logic        last_region;

	modport source (output valid, region_x, region_y, region_width, region_height,
		source_offset, last_region, input ready);
	modport sink (input valid, region_x, region_y, region_width, region_height,
		source_offset, last_region, output ready);
endinterface
`default_nettype wire

>>> design/lrcs_div.sv
`default_nettype none
// Pipelined restoring divider: a 32-bit dividend by a divisor of up to 15 bits,
// four quotient bits per stage. All stages move together on en.
module lrcs_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] num,
	input  wire logic [14:0] den,
	output logic      [31:0] quo,
	output logic      [14:0] rem
);

	typedef struct packed {
		logic [14:0] rem;
		logic [31:0] num;
		logic [14:0] den;
	} div_st_t;

	div_st_t st_s [lrcs_pkg::DIV_STAGES];

	// The dividend shifts out at the top while quotient bits shift in below.
	function automatic div_st_t div_step(div_st_t a);
		div_st_t     r;
		logic [15:0] t;
		logic        ge;
		r = a;
		for (int i = 0; i < lrcs_pkg::DIV_STEP; i++) begin
			t = {r.rem, r.num[31]};
			ge = (t >= {1'b0, r.den});
			r.num = {r.num[30:0], ge};
			r.rem = ge ? 15'(t - {1'b0, r.den}) : t[14:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step('{rem: 15'd0, num: num, den: den});
			for (int k = 1; k < lrcs_pkg::DIV_STAGES; k++) begin
				st_s[k] <= div_step(st_s[k-1]);
			end
		end
	end

	assign quo = st_s[lrcs_pkg::DIV_STAGES-1].num;
	assign rem = st_s[lrcs_pkg::DIV_STAGES-1].rem;

endmodule
`default_nettype wire

>>> design/linear_to_rect_copy_split_core.sv
`default_nettype none
// Pipeline: three divider steps of eight stages each (bytes to texels,
// row and column, full rows), then three arithmetic stages and the region buffer.
// Flow: a request can enter every cycle unless the region buffer stalls; regions
// leave one per cycle while ready is high, and the pipe waits for the last one.
// Reset: arst_n clears all valid bits and the pending region mask at once and
// sets tb_q to 4; the block takes requests in the first cycle after.
module linear_to_rect_copy_split_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata,
	lrcs_req_if.sink        req,
	lrcs_rgn_if.source      rgn
);

	localparam int unsigned DS = lrcs_pkg::DIV_STAGES;
	// Stage positions along the valid chain.
	localparam int unsigned V_LEN = 3 * DS + 3;
	localparam int unsigned V_C = 2 * DS - 1;
	localparam int unsigned V_H = 2 * DS;
	localparam int unsigned V_F = 3 * DS + 1;
	localparam int unsigned V_M = 3 * DS + 2;

	typedef struct packed {
		logic [14:0] w;
		logic [4:0]  tb;
	} side_a_t;

	typedef struct packed {
		logic [31:0] remain;
		logic [14:0] w;
		logic [4:0]  tb;
	} side_c_t;

	typedef struct packed {
		logic        has_head;
		logic [13:0] col;
		logic [31:0] row;
		logic [14:0] hcopy;
		logic [31:0] remain;
		logic [14:0] w;
		logic [4:0]  tb;
	} side_d_t;

	logic [4:0] tb_q;
	logic       en;
	logic [V_LEN-1:0] v_q;

	// The configuration register is written directly; software must write it only
	// while no request is in flight, as the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q <= 5'(lrcs_pkg::TB_RESET);
		end else if (cfg_we) begin
			tb_q <= cfg_wdata;
		end
	end

	// Every stage advances together whenever the region buffer can take the
	// oldest request or is about to free up.
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[V_LEN-2:0], req.valid};
		end
	end

	// Input conditioning: zero texel size or zero width acts as one, width is clamped.
	logic [4:0]  tb_eff;
	logic [14:0] w_eff;
	assign tb_eff = (tb_q == 5'd0) ? 5'd1 : tb_q;
	always_comb begin
		if (req.texture_width == 15'd0) begin
			w_eff = 15'd1;
		end else if (req.texture_width > 15'(lrcs_pkg::MAX_TEXTURE_WIDTH)) begin
			w_eff = 15'(lrcs_pkg::MAX_TEXTURE_WIDTH);
		end else begin
			w_eff = req.texture_width;
		end
	end

	// Bytes to texels: start and length divided by the texel size in parallel.
	logic [31:0] start_q_a, remain_q_a;
	logic [14:0] unused_ra, unused_rb;
	side_a_t     side_a_s [DS];

	lrcs_div u_div_start (
		.clk(clk), .en(en), .num(req.start_byte), .den({10'd0, tb_eff}),
		.quo(start_q_a), .rem(unused_ra)
	);
	lrcs_div u_div_len (
		.clk(clk), .en(en), .num(req.byte_length), .den({10'd0, tb_eff}),
		.quo(remain_q_a), .rem(unused_rb)
	);

	// Start texel to row and column.
	logic [31:0] row_c;
	logic [14:0] col_c;
	side_c_t     side_c_s [DS];

	lrcs_div u_div_row (
		.clk(clk), .en(en), .num(start_q_a), .den(side_a_s[DS-1].w),
		.quo(row_c), .rem(col_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_a_s[0] <= '{w: w_eff, tb: tb_eff};
			side_c_s[0] <= '{remain: remain_q_a, w: side_a_s[DS-1].w, tb: side_a_s[DS-1].tb};
			for (int k = 1; k < DS; k++) begin
				side_a_s[k] <= side_a_s[k-1];
				side_c_s[k] <= side_c_s[k-1];
			end
		end
	end

	// Head stage: the rest of a partly used row, clipped to what is copied.
	side_d_t     h_s1;
	logic [14:0] room;
	logic [14:0] hcopy;
	logic        has_head;
	assign room = side_c_s[DS-1].w - col_c;
	assign hcopy = (side_c_s[DS-1].remain < {17'd0, room})
		? side_c_s[DS-1].remain[14:0] : room;
	assign has_head = (col_c != 15'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1.has_head <= has_head;
			h_s1.col      <= col_c[13:0];
			h_s1.row      <= row_c + {31'd0, has_head};
			h_s1.hcopy    <= has_head ? hcopy : 15'd0;
			h_s1.remain   <= side_c_s[DS-1].remain - (has_head ? {17'd0, hcopy} : 32'd0);
			h_s1.w        <= side_c_s[DS-1].w;
			h_s1.tb       <= side_c_s[DS-1].tb;
		end
	end

	// Full rows: the remaining texels divided by the width.
	logic [31:0] rows_d;
	logic [14:0] left_d;
	side_d_t     side_d_s [DS];

	lrcs_div u_div_rows (
		.clk(clk), .en(en), .num(h_s1.remain), .den(h_s1.w),
		.quo(rows_d), .rem(left_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_d_s[0] <= h_s1;
			for (int k = 1; k < DS; k++) begin
				side_d_s[k] <= side_d_s[k-1];
			end
		end
	end

	// Region stage: head, block and tail geometry, the region mask, and texel counts
	// before block and tail. The row of the head request was already advanced past the head row.
	side_d_t              d;
	logic                 big;
	lrcs_pkg::region_t    head_f_s2, block_f_s2, tail_f_s2;
	logic [2:0]           mask_s2;
	logic [31:0]          begin_b_s2, begin_t_s2;
	logic [4:0]           tb_s2;
	assign d = side_d_s[DS-1];
	assign big = (d.remain > {17'd0, d.w});

	always_ff @(posedge clk) begin
		if (en) begin
			head_f_s2  <= '{x: d.col, y: d.row - 32'd1, width: d.hcopy,
				height: 32'd1, offset: 32'd0};
			block_f_s2 <= '{x: 14'd0, y: d.row, width: big ? d.w : d.remain[14:0],
				height: big ? rows_d : 32'd1, offset: 32'd0};
			tail_f_s2  <= '{x: 14'd0, y: d.row + rows_d, width: left_d,
				height: 32'd1, offset: 32'd0};
			mask_s2    <= {big && (left_d != 15'd0), d.remain != 32'd0, d.has_head};
			begin_b_s2 <= {17'd0, d.hcopy};
			begin_t_s2 <= {17'd0, d.hcopy} + d.remain - {17'd0, left_d};
			tb_s2      <= d.tb;
		end
	end

	// Offset stage: texels before the block and tail regions scaled to bytes.
	lrcs_pkg::region_t    rg_s3 [3];
	logic [2:0]           mask_s3;
	logic [36:0]          prod_b, prod_t;
	assign prod_b = 37'(begin_b_s2) * 37'(tb_s2);
	assign prod_t = 37'(begin_t_s2) * 37'(tb_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s3[0] <= head_f_s2;
			rg_s3[1] <= '{x: block_f_s2.x, y: block_f_s2.y, width: block_f_s2.width,
				height: block_f_s2.height, offset: prod_b[31:0]};
			rg_s3[2] <= '{x: tail_f_s2.x, y: tail_f_s2.y, width: tail_f_s2.width,
				height: tail_f_s2.height, offset: prod_t[31:0]};
			mask_s3  <= mask_s2;
		end
	end

	// Region buffer: holds one request's regions and sends them lowest first.
	logic [2:0]        pend_q;
	lrcs_pkg::region_t buf_q [3];
	logic [1:0]        sel;
	logic              one_left;

	always_comb begin
		if (pend_q[0]) begin
			sel = 2'd0;
		end else if (pend_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end
	assign one_left = ($countones(pend_q) == 1);
	assign en = (pend_q == 3'b000) || (rgn.ready && one_left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'b000;
		end else if (en) begin
			pend_q <= v_q[V_M] ? mask_s3 : 3'b000;
		end else if (rgn.ready) begin
			pend_q[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			buf_q <= rg_s3;
		end
	end

	assign rgn.valid         = (pend_q != 3'b000);
	assign rgn.region_x      = buf_q[sel].x;
	assign rgn.region_y      = buf_q[sel].y;
	assign rgn.region_width  = buf_q[sel].width;
	assign rgn.region_height = buf_q[sel].height;
	assign rgn.source_offset = buf_q[sel].offset;
	assign rgn.last_region   = one_left;

`ifndef SYNTH
	// A request with a tail region always carries a block region as well.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[V_M] && mask_s3[2]) |-> mask_s3[1])
		else $error("tail region without block");
	// An empty buffer always lets the pipeline advance.
	assert property (@(posedge clk) disable iff (!arst_n) (pend_q == 3'b000) |-> req.ready)
		else $error("pipeline stalled with empty buffer");
	// A stalled region keeps the pending region mask.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rgn.valid && !rgn.ready) |=> $stable(pend_q))
		else $error("pending mask changed under stall");
	// While the pipe stalls, the valid chain holds at positions V_C, V_H and V_F.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q[V_C]) && $stable(v_q[V_H]) && $stable(v_q[V_F]))
		else $error("valid chain moved during stall");
`endif

endmodule
`default_nettype wire

>>> dv/lrcs_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces come with the RTL; this file holds the
// testbench's shared expectation type.
package lrcs_tb_pkg;

	typedef struct packed {
		logic [13:0] x;
		logic [31:0] y;
		logic [14:0] width;
		logic [31:0] height;
		logic [31:0] offset;
		logic        last;
	} expected_region_t;

endpackage

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

	// Idling modes for the request and region sides.
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam int unsigned DRAIN_CYCLES = 40;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	lrcs_req_if req ();
	lrcs_rgn_if rgn ();

	linear_to_rect_copy_split_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rgn       (rgn)
	);

	int error_count = 0;
	longint unsigned cycle_count = 0;

	// Prints one line per mismatch and keeps the tally.
	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Predicts the regions that one copy request yields and checks the
	// regions that come out against them, oldest first.
	class region_scoreboard;
		lrcs_tb_pkg::expected_region_t pending[$];
		logic [4:0] texel_size = 5'(lrcs_pkg::TB_RESET);

		function void set_texel_size(logic [4:0] value);
			texel_size = value;
		endfunction

		function void push_region(logic [63:0] x, logic [63:0] y, logic [63:0] w,
			logic [63:0] h, logic [63:0] src);
			lrcs_tb_pkg::expected_region_t r;
			r.x = x[13:0];
			r.y = y[31:0];
			r.width = w[14:0];
			r.height = h[31:0];
			r.offset = src[31:0];
			r.last = 1'b0;
			pending.push_back(r);
		endfunction

		// Splits one accepted request into head, block and tail rectangles.
		function void note_request(logic [31:0] start_byte, logic [31:0] byte_length,
			logic [14:0] texture_width);
			logic [63:0] tsz, wid, start, remain, col, row, copy, done, rw, rh;
			int prior_count;
			prior_count = pending.size();
			tsz = (texel_size == 0) ? 64'd1 : 64'(texel_size);
			wid = (texture_width == 0) ? 64'd1 : 64'(texture_width);
			if (wid > lrcs_pkg::MAX_TEXTURE_WIDTH)
				wid = lrcs_pkg::MAX_TEXTURE_WIDTH;
			start = 64'(start_byte) / tsz;
			remain = 64'(byte_length) / tsz;
			col = start % wid;
			row = start / wid;
			done = 0;
			if (col > 0) begin
				copy = wid - col;
				if (remain < copy)
					copy = remain;
				push_region(col, row, copy, 1, 0);
				row += 1;
				remain -= copy;
				done += copy;
			end
			if (remain > 0) begin
				if (remain > wid) begin
					rw = wid;
					rh = remain / wid;
				end else begin
					rw = remain;
					rh = 1;
				end
				push_region(0, row, rw, rh, done * tsz);
				row += rh;
				remain -= rw * rh;
				done += rw * rh;
			end
			if (remain > 0)
				push_region(0, row, remain, 1, done * tsz);
			if (pending.size() > prior_count)
				pending[pending.size() - 1].last = 1'b1;
		endfunction

		task check_region(lrcs_tb_pkg::expected_region_t got);
			lrcs_tb_pkg::expected_region_t exp_r;
			if (pending.size() == 0) begin
				report_mismatch("region with no request outstanding");
				return;
			end
			exp_r = pending.pop_front();
			if (got.x !== exp_r.x)
				report_mismatch($sformatf("x %0d, want %0d", got.x, exp_r.x));
			if (got.y !== exp_r.y)
				report_mismatch($sformatf("y %0d, want %0d", got.y, exp_r.y));
			if (got.width !== exp_r.width)
				report_mismatch($sformatf("width %0d, want %0d", got.width, exp_r.width));
			if (got.height !== exp_r.height)
				report_mismatch($sformatf("height %0d, want %0d", got.height, exp_r.height));
			if (got.offset !== exp_r.offset)
				report_mismatch($sformatf("offset %0d, want %0d", got.offset, exp_r.offset));
			if (got.last !== exp_r.last)
				report_mismatch($sformatf("last %0b, want %0b", got.last, exp_r.last));
		endtask
	endclass

	region_scoreboard regions = new();

	idle_mode_t idle_mode = IDLE_NONE;
	// While set, the region side holds ready low regardless of the mode.
	bit hold_off = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Reset is applied once, with every input at a known value.
	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		req.valid = 0;
		req.start_byte = 0;
		req.byte_length = 0;
		req.texture_width = 1;
		rgn.ready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// The cycle counter is the only guard against a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The region side stalls at random according to the mode, and always
	// during reset or a hold-off.
	always @(posedge clk) begin
		if (!arst_n || hold_off)
			rgn.ready <= 0;
		else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
			rgn.ready <= ($urandom_range(99) >= 56);
		else
			rgn.ready <= 1;
	end

	// Every region taken by the handshake goes to the scoreboard. Sampling at
	// the edge sees the values from before any nonblocking update.
	always @(posedge clk) begin
		lrcs_tb_pkg::expected_region_t got;
		if (arst_n && rgn.valid && rgn.ready) begin
			got.x = rgn.region_x;
			got.y = rgn.region_y;
			got.width = rgn.region_width;
			got.height = rgn.region_height;
			got.offset = rgn.source_offset;
			got.last = rgn.last_region;
			regions.check_region(got);
		end
	end

	// Offers one request and waits until it is accepted. The prediction is made
	// at the accepting edge so that configuration order is kept. Valid stays
	// high after the accept; whoever idles next drops it.
	task automatic send_request(logic [31:0] start_byte, logic [31:0] byte_length,
		logic [14:0] texture_width);
		if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
			while ($urandom_range(99) < 56) begin
				req.valid <= 0;
				@(posedge clk);
			end
		req.valid <= 1;
		req.start_byte <= start_byte;
		req.byte_length <= byte_length;
		req.texture_width <= texture_width;
		do
			@(posedge clk);
		while (!req.ready);
		regions.note_request(start_byte, byte_length, texture_width);
	endtask

	// Waits until every predicted region has come, then lets the pipe settle,
	// since an empty copy may still be in flight.
	task automatic drain_regions();
		req.valid <= 0;
		while (regions.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the texel size while the block is idle.
	task automatic write_texel_size(logic [4:0] value);
		drain_regions();
		cfg_we <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 0;
		regions.set_texel_size(value);
	endtask

	// Random request. Most are small copies with small widths so that all three
	// rectangles show up often; the rest use the full ranges or out-of-range widths.
	task automatic send_random();
		logic [31:0] sb, bl;
		logic [14:0] tw;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			tw = 15'($urandom_range(64, 1));
			sb = $urandom_range(4000);
			bl = $urandom_range(3000);
		end else if (pick < 85) begin
			tw = 15'($urandom_range(16384, 1));
			sb = $urandom;
			bl = $urandom;
		end else begin
			tw = 15'($urandom);
			sb = $urandom;
			bl = $urandom_range(40);
		end
		send_request(sb, bl, tw);
	endtask

	initial begin
		logic [4:0] sizes[6];
		sizes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8};
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed cases at the reset texel size of four bytes.
		send_request(0, 0, 1);                        // empty copy
		send_request(4, 0, 10);                       // head of zero width
		send_request(8, 100, 10);                     // head, block, tail
		send_request(0, 40, 10);                      // exactly one row
		send_request(0, 44, 10);                      // row plus tail
		send_request(0, 3, 10);                       // less than one texel
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF); // clamped width
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);        // zero width
		send_request(0, 32'hFFFF_FFFF, 1);            // tall narrow block
		send_request(12, 8, 16384);                   // short head only
		send_request(32'hAAAA_AAAA, 32'h5555_5555, 15'h5555);
		send_request(32'h5555_5555, 32'hAAAA_AAAA, 15'h2AAA);
		drain_regions();

		// Texel size one with the widest copy: region_y runs far down.
		write_texel_size(5'd1);
		send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1);
		send_request(32'd5, 32'd1, 7);

		// Random phases across texel sizes, extremes and out-of-range values.
		for (int phase = 0; phase < 8; phase++) begin
			write_texel_size(sizes[phase % 6]);
			idle_mode = idle_mode_t'(phase % 4);
			if (phase == 2) begin
				// Long hold-off on the region side while requests keep coming.
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					for (int i = 0; i < 40; i++)
						send_random();
				join
			end else begin
				for (int i = 0; i < 30; i++)
					send_random();
			end
			if (phase == 5) begin
				// The request side pauses until every region is back.
				req.valid <= 0;
				while (regions.pending.size() != 0)
					@(posedge clk);
				for (int i = 0; i < 5; i++)
					send_random();
			end
		end

		drain_regions();
		if (error_count == 0 && regions.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
